// ===== sv/bfm_pkg.sv =====
package bfm_pkg;
   localparam int FRAMES = 16;
   localparam int PAGE_BITS = 24;
   localparam int PIN_BITS = 8;
   localparam int IDX_BITS = 4;
   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   localparam logic [2:0] OP_PIN   = 3'd0;
   localparam logic [2:0] OP_UNPIN = 3'd1;
   localparam logic [2:0] OP_DIRTY = 3'd2;
   localparam logic [2:0] OP_FORCE = 3'd3;
   localparam logic [2:0] OP_FLUSH = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_NOFRAME = 2'd2;
   localparam logic [1:0] ST_UNDER   = 2'd3;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_FRAMES = 1'b1;

   typedef struct packed {
      logic [IDX_BITS-1:0]  frame_index;
      logic                 hit;
      logic                 write_back;
      logic [PAGE_BITS-1:0] write_back_page;
      logic                 load_needed;
      logic [1:0]           status;
      logic                 last;
      logic [31:0]          read_count;
      logic [31:0]          write_count;
   } rsp_type;
endpackage

// ===== sv/buffer_frame_manager.sv =====
// Channel   | Direction | Content
// req_      | in        | tdata: opcode[2:0], page_number[26:3]
// rsp_      | out       | tdata: frame_index, hit, write_back, write_back_page,
//           |           |        load_needed, status, read_count, write_count; tlast
// csr_      | in        | index 0 replace_policy, 1 frames_in_use
// A request walks the frame table one frame per cycle; n is the active count. Pin,
// unpin, mark dirty and force look the page up in the first n frames and stop at a
// hit. A pin miss then scans n frames for the lowest free frame or else a victim: the
// oldest unpinned use stamp with LRU, the first unpinned frame from the FIFO pointer
// with FIFO, after that pointer is brought below n by repeated subtraction. Flush
// sends one transfer per written frame, or one when none is written. A result waiting
// on rsp_tready holds the block. Reset clears valid, pins, dirty marks and counters.
module buffer_frame_manager (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,    // opcode[2:0], page_number[26:3]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,    // frame_index[3:0], hit[4], write_back[5],
                                      // write_back_page[29:6], load_needed[30],
                                      // status[32:31], read_count[64:33],
                                      // write_count[96:65], zero pad above
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [4:0]   csr_data
);
   import bfm_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_FIND = 3'd1, S_MOD = 3'd2, S_VIC = 3'd3,
                          S_ACT = 3'd4, S_OUT = 3'd5, S_FLUSH = 3'd6;

   logic [PAGE_BITS-1:0] page_mem [FRAMES];
   logic [FRAMES-1:0]    valid_ff, dirty_ff;
   logic [PIN_BITS-1:0]  pin_ff [FRAMES];
   logic [31:0]          stamp_ff [FRAMES];
   logic [IDX_BITS-1:0]  fifo_ff;
   logic [31:0]          clk_ff, reads_ff, writes_ff;
   logic                 policy_ff;
   logic [4:0]           fiu_ff;
   logic [2:0]           state_ff;
   logic [2:0]           op_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [IDX_BITS:0]    cnt_ff;
   logic [IDX_BITS-1:0]  ptr_ff, best_ff, free_ff;
   logic                 found_ff, free_ok_ff, any_ff, emitted_ff;
   rsp_type              rsp_ff;
   logic [4:0]           n;
   logic [IDX_BITS-1:0]  vic;
   logic [IDX_BITS-1:0]  scan;
   logic [FRAMES-1:0]    flush_cand, upto_mask;

   assign n = (fiu_ff == 5'd0) ? 5'd1 : (fiu_ff > 5'(FRAMES) ? 5'(FRAMES) : fiu_ff);
   assign vic = free_ok_ff ? free_ff : best_ff;
   assign scan = cnt_ff[IDX_BITS-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast = rsp_ff.last;
   assign rsp_tdata = {7'd0, rsp_ff.write_count, rsp_ff.read_count, rsp_ff.status,
                       rsp_ff.load_needed, rsp_ff.write_back_page, rsp_ff.write_back,
                       rsp_ff.hit, rsp_ff.frame_index};

   // frames that flush would write, and the frames up to the current one
   always_comb begin
      for (int i = 0; i < FRAMES; i++)
         flush_cand[i] = valid_ff[i] && dirty_ff[i] && (pin_ff[i] == '0) && (5'(i) < n);
   end
   assign upto_mask = (FRAMES'(2) << scan) - FRAMES'(1);

   task automatic put(input logic [IDX_BITS-1:0] fi, input logic h, input logic wb,
                      input logic [PAGE_BITS-1:0] wp, input logic ld,
                      input logic [1:0] st, input logic ls,
                      input logic [31:0] rc, input logic [31:0] wc);
      rsp_ff <= {fi, h, wb, wp, ld, st, ls, rc, wc};
   endtask

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; dirty_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin pin_ff[i] <= '0; stamp_ff[i] <= '0; end
         fifo_ff <= '0; clk_ff <= '0; reads_ff <= '0; writes_ff <= '0;
         policy_ff <= 1'b0; fiu_ff <= 5'd16; rsp_ff <= '0;
      end else begin
         // take register writes while idle
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POLICY) policy_ff <= csr_data[0];
            else if (csr_index == CSR_FRAMES) fiu_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               op_ff <= req_tdata[2:0];
               page_ff <= req_tdata[26:3];
               ptr_ff <= '0; cnt_ff <= '0; found_ff <= 1'b0; any_ff <= 1'b0;
               free_ok_ff <= 1'b0; emitted_ff <= 1'b0;
               if (req_tdata[2:0] == OP_FLUSH) state_ff <= S_FLUSH;
               else if (req_tdata[2:0] <= OP_FORCE) state_ff <= S_FIND;
            end
            // look up the page one frame per cycle
            S_FIND: begin
               if (valid_ff[ptr_ff] && page_mem[ptr_ff] == page_ff) begin
                  found_ff <= 1'b1; best_ff <= ptr_ff; state_ff <= S_ACT;
               end else if (cnt_ff + 5'd1 >= n) begin
                  cnt_ff <= '0;
                  if (op_ff == OP_PIN) begin
                     if (policy_ff) begin
                        ptr_ff <= '0; state_ff <= S_VIC;
                     end else begin
                        ptr_ff <= fifo_ff; state_ff <= S_MOD;
                     end
                  end else state_ff <= S_ACT;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1; ptr_ff <= ptr_ff + 4'd1;
               end
            end
            // reduce the FIFO pointer below the active count by repeated subtraction
            S_MOD: begin
               if (5'(ptr_ff) >= n) ptr_ff <= ptr_ff - n[IDX_BITS-1:0];
               else state_ff <= S_VIC;
            end
            // track the lowest free frame and the FIFO or LRU candidate
            S_VIC: begin
               if (!free_ok_ff && !valid_ff[scan]) begin
                  free_ok_ff <= 1'b1; free_ff <= scan;
               end
               if (pin_ff[ptr_ff] == '0 &&
                   (!any_ff || (policy_ff && stamp_ff[ptr_ff] < stamp_ff[best_ff]))) begin
                  any_ff <= 1'b1; best_ff <= ptr_ff;
               end
               if (cnt_ff + 5'd1 >= n) state_ff <= S_ACT;
               cnt_ff <= cnt_ff + 5'd1;
               ptr_ff <= (5'(ptr_ff) + 5'd1 >= n) ? '0 : ptr_ff + 4'd1;
            end
            S_ACT: begin
               state_ff <= S_OUT;
               if (op_ff == OP_PIN && found_ff) begin
                  if (pin_ff[best_ff] != PIN_MAX)
                     pin_ff[best_ff] <= pin_ff[best_ff] + PIN_BITS'(1);
                  clk_ff <= clk_ff + 32'd1; stamp_ff[best_ff] <= clk_ff + 32'd1;
                  put(best_ff, 1'b1, 1'b0, '0, 1'b0, ST_OK, 1'b1, reads_ff, writes_ff);
               end else if (op_ff == OP_PIN) begin
                  if (!free_ok_ff && !any_ff)
                     put('0, 1'b0, 1'b0, '0, 1'b0, ST_NOFRAME, 1'b1, reads_ff, writes_ff);
                  else begin
                     page_mem[vic] <= page_ff; valid_ff[vic] <= 1'b1;
                     pin_ff[vic] <= PIN_BITS'(1); dirty_ff[vic] <= 1'b0;
                     clk_ff <= clk_ff + 32'd1; stamp_ff[vic] <= clk_ff + 32'd1;
                     reads_ff <= reads_ff + 32'd1;
                     fifo_ff <= (5'(vic) + 5'd1 >= n) ? '0 : vic + 4'd1;
                     if (valid_ff[vic] && dirty_ff[vic]) begin
                        writes_ff <= writes_ff + 32'd1;
                        put(vic, 1'b0, 1'b1, page_mem[vic], 1'b1, ST_OK, 1'b1,
                            reads_ff + 32'd1, writes_ff + 32'd1);
                     end else
                        put(vic, 1'b0, 1'b0, '0, 1'b1, ST_OK, 1'b1,
                            reads_ff + 32'd1, writes_ff);
                  end
               end else if (!found_ff)
                  put('0, 1'b0, 1'b0, '0, 1'b0, ST_MISSING, 1'b1, reads_ff, writes_ff);
               else if (op_ff == OP_UNPIN) begin
                  if (pin_ff[best_ff] == '0)
                     put(best_ff, 1'b0, 1'b0, '0, 1'b0, ST_UNDER, 1'b1, reads_ff, writes_ff);
                  else begin
                     pin_ff[best_ff] <= pin_ff[best_ff] - PIN_BITS'(1);
                     put(best_ff, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b1, reads_ff, writes_ff);
                  end
               end else if (op_ff == OP_DIRTY) begin
                  dirty_ff[best_ff] <= 1'b1;
                  put(best_ff, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b1, reads_ff, writes_ff);
               end else begin
                  dirty_ff[best_ff] <= 1'b0; writes_ff <= writes_ff + 32'd1;
                  put(best_ff, 1'b0, 1'b1, page_mem[best_ff], 1'b0, ST_OK, 1'b1,
                      reads_ff, writes_ff + 32'd1);
               end
            end
            // write back dirty unpinned frames in order, one transfer each
            S_FLUSH: begin
               if (cnt_ff >= n) begin
                  if (emitted_ff) state_ff <= S_IDLE;
                  else begin
                     state_ff <= S_OUT;
                     put('0, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b1, reads_ff, writes_ff);
                  end
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
                  if (flush_cand[scan]) begin
                     dirty_ff[scan] <= 1'b0; writes_ff <= writes_ff + 32'd1;
                     emitted_ff <= 1'b1; state_ff <= S_OUT;
                     put(scan, 1'b0, 1'b1, page_mem[scan], 1'b0, ST_OK,
                         ~|(flush_cand & ~upto_mask), reads_ff, writes_ff + 32'd1);
                  end
               end
            end
            S_OUT: if (rsp_tready)
               state_ff <= (op_ff == OP_FLUSH && !rsp_ff.last) ? S_FLUSH : S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== tb/sv/bfm_checker.sv =====
module bfm_checker
   import bfm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_index,
   input  logic [4:0]   csr_data,
   output int           errors,
   output int           pending
);

   // shadow copy of the frame table and the registers
   logic                 policy_lru;
   logic [4:0]           frames_cfg;
   logic [PAGE_BITS-1:0] page_of [FRAMES];
   logic                 valid_of [FRAMES];
   logic [PIN_BITS-1:0]  pins_of [FRAMES];
   logic                 dirty_of [FRAMES];
   logic [31:0]          stamp_of [FRAMES];
   int                   fifo_ptr;
   logic [31:0]          use_clk;
   logic [31:0]          reads;
   logic [31:0]          writes;
   rsp_type              expected_rsp [$];

   function automatic int active_frames();
      int n;
      n = int'(frames_cfg);
      if (n < 1) n = 1;
      if (n > FRAMES) n = FRAMES;
      return n;
   endfunction

   function automatic int lookup(logic [PAGE_BITS-1:0] page, int n);
      for (int i = 0; i < n; i++)
         if (valid_of[i] && page_of[i] == page) return i;
      return -1;
   endfunction

   function automatic int pick_victim(int n);
      int f;
      int best;
      best = -1;
      for (int i = 0; i < n; i++)
         if (!valid_of[i]) return i;
      if (!policy_lru) begin
         f = fifo_ptr % n;
         for (int i = 0; i < n; i++) begin
            if (pins_of[f] == '0) return f;
            f = (f + 1) % n;
         end
         return -1;
      end
      for (int i = 0; i < n; i++) begin
         if (pins_of[i] != '0) continue;
         if (best < 0 || stamp_of[i] < stamp_of[best]) best = i;
      end
      return best;
   endfunction

   // queue one expected transfer with the current counters
   function automatic void push_rsp(int f, logic hit, logic wb, logic [PAGE_BITS-1:0] wbp,
                                    logic load, logic [1:0] st, logic lst);
      rsp_type r;
      r.frame_index     = f[IDX_BITS-1:0];
      r.hit             = hit;
      r.write_back      = wb;
      r.write_back_page = wbp;
      r.load_needed     = load;
      r.status          = st;
      r.last            = lst;
      r.read_count      = reads;
      r.write_count     = writes;
      expected_rsp.push_back(r);
   endfunction

   // advance the shadow state for one accepted request
   function automatic void predict_request(logic [2:0] op, logic [PAGE_BITS-1:0] page);
      int n;
      int f;
      int first_q;
      logic wb;
      logic [PAGE_BITS-1:0] wbp;
      n = active_frames();
      case (op)
         OP_PIN: begin
            f = lookup(page, n);
            if (f >= 0) begin
               if (pins_of[f] != PIN_MAX) pins_of[f]++;
               use_clk++;
               stamp_of[f] = use_clk;
               push_rsp(f, 1'b1, 1'b0, '0, 1'b0, ST_OK, 1'b1);
            end else begin
               f = pick_victim(n);
               if (f < 0) begin
                  push_rsp(0, 1'b0, 1'b0, '0, 1'b0, ST_NOFRAME, 1'b1);
               end else begin
                  wb = 1'b0;
                  wbp = '0;
                  if (valid_of[f] && dirty_of[f]) begin
                     wb = 1'b1;
                     wbp = page_of[f];
                     writes++;
                  end
                  page_of[f]  = page;
                  valid_of[f] = 1'b1;
                  pins_of[f]  = PIN_BITS'(1);
                  dirty_of[f] = 1'b0;
                  use_clk++;
                  stamp_of[f] = use_clk;
                  reads++;
                  fifo_ptr = (f + 1) % n;
                  push_rsp(f, 1'b0, wb, wbp, 1'b1, ST_OK, 1'b1);
               end
            end
         end
         OP_UNPIN, OP_DIRTY, OP_FORCE: begin
            f = lookup(page, n);
            if (f < 0) begin
               push_rsp(0, 1'b0, 1'b0, '0, 1'b0, ST_MISSING, 1'b1);
            end else if (op == OP_UNPIN) begin
               if (pins_of[f] == '0) begin
                  push_rsp(f, 1'b0, 1'b0, '0, 1'b0, ST_UNDER, 1'b1);
               end else begin
                  pins_of[f]--;
                  push_rsp(f, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b1);
               end
            end else if (op == OP_DIRTY) begin
               dirty_of[f] = 1'b1;
               push_rsp(f, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b1);
            end else begin
               dirty_of[f] = 1'b0;
               writes++;
               push_rsp(f, 1'b0, 1'b1, page_of[f], 1'b0, ST_OK, 1'b1);
            end
         end
         OP_FLUSH: begin
            first_q = expected_rsp.size();
            for (int i = 0; i < n; i++) begin
               if (valid_of[i] && dirty_of[i] && pins_of[i] == '0) begin
                  dirty_of[i] = 1'b0;
                  writes++;
                  push_rsp(i, 1'b0, 1'b1, page_of[i], 1'b0, ST_OK, 1'b0);
               end
            end
            if (expected_rsp.size() == first_q) push_rsp(0, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b1);
            else expected_rsp[$].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, longint unsigned exp_v,
                                       longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         policy_lru = 1'b0;
         frames_cfg = 5'd16;
         for (int i = 0; i < FRAMES; i++) begin
            page_of[i]  = '0;
            valid_of[i] = 1'b0;
            pins_of[i]  = '0;
            dirty_of[i] = 1'b0;
            stamp_of[i] = '0;
         end
         fifo_ptr = 0;
         use_clk  = '0;
         reads    = '0;
         writes   = '0;
         errors   = 0;
         expected_rsp.delete();
      end else begin
         // compare the result transfer first: it belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result transfer: %h", rsp_tdata);
               errors++;
            end else begin
               exp_r = expected_rsp.pop_front();
               check_field("frame_index", exp_r.frame_index, rsp_tdata[3:0]);
               check_field("hit", exp_r.hit, rsp_tdata[4]);
               check_field("write_back", exp_r.write_back, rsp_tdata[5]);
               check_field("write_back_page", exp_r.write_back_page, rsp_tdata[29:6]);
               check_field("load_needed", exp_r.load_needed, rsp_tdata[30]);
               check_field("status", exp_r.status, rsp_tdata[32:31]);
               check_field("last", exp_r.last, rsp_tlast);
               check_field("read_count", exp_r.read_count, rsp_tdata[64:33]);
               check_field("write_count", exp_r.write_count, rsp_tdata[96:65]);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POLICY) policy_lru = csr_data[0];
            else frames_cfg = csr_data;
         end
         if (req_tvalid && req_tready) predict_request(req_tdata[2:0], req_tdata[26:3]);
      end
      pending = expected_rsp.size();
   end

endmodule

// ===== tb/sv/tb_buffer_frame_manager.sv =====
module tb_buffer_frame_manager;
   import bfm_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [4:0]   csr_data;
   int           errors;
   int           pending;

   logic        quiet;
   logic        hold_request;
   logic [PAGE_BITS-1:0] page_pool [24];
   int          pool_size;

   buffer_frame_manager DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   bfm_checker bfm_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .errors(errors), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // drain results, with random stalls and one long hold-off on request
   initial begin
      logic held;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // end the run when no channel has moved for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 3000) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send(logic [2:0] op, logic [PAGE_BITS-1:0] page);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, page, op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(logic idx, logic [4:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // wait for every result, then let a pending scan finish before a write
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic setup_phase(logic lru, logic [4:0] frames, int spread);
      settle();
      write_csr(CSR_POLICY, {4'd0, lru});
      write_csr(CSR_FRAMES, frames);
      csr_valid <= 1'b0;
      pool_size = spread;
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < 24; i++) page_pool[i] = 24'($urandom_range(0, 24'hFFFFFF));
   endtask

   task automatic random_items(int count);
      int r;
      logic [2:0] op;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 40) op = OP_PIN;
         else if (r < 65) op = OP_UNPIN;
         else if (r < 80) op = OP_DIRTY;
         else if (r < 88) op = OP_FORCE;
         else if (r < 95) op = OP_FLUSH;
         else op = 3'($urandom_range(5, 7));
         if ($urandom_range(0, 19) == 0)
            send(op, 24'($urandom_range(0, 24'hFFFFFF)));
         else
            send(op, page_pool[$urandom_range(0, pool_size - 1)]);
      end
   endtask

   initial begin
      quiet        = 1'b0;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = 1'b0;
      csr_data     = '0;
      pool_size    = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, missing pages, underflow
      setup_phase(1'b0, 5'd16, 4);
      send(OP_PIN, 24'h000000);
      send(OP_PIN, 24'hFFFFFF);
      send(OP_PIN, 24'h000000);
      send(OP_DIRTY, 24'h000000);
      send(OP_FORCE, 24'hFFFFFF);
      send(OP_UNPIN, 24'h000000);
      send(OP_UNPIN, 24'h000000);
      send(OP_UNPIN, 24'h000000);
      send(OP_UNPIN, 24'h123456);
      send(OP_DIRTY, 24'hABCDEF);
      send(OP_FORCE, 24'h555555);
      send(3'd5, 24'hAAAAAA);
      send(3'd6, 24'h555555);
      send(3'd7, 24'hFFFFFF);
      send(OP_FLUSH, 24'h000000);
      send(OP_UNPIN, 24'hFFFFFF);
      send(OP_DIRTY, 24'hFFFFFF);
      send(OP_FLUSH, 24'hFFFFFF);
      send(OP_FLUSH, 24'h000000);

      // two frames: fill, pin both, then a miss finds no free frame
      setup_phase(1'b1, 5'd2, 4);
      send(OP_PIN, 24'h000011);
      send(OP_PIN, 24'h000022);
      send(OP_PIN, 24'h000033);
      send(OP_UNPIN, 24'h000011);
      send(OP_DIRTY, 24'h000011);
      send(OP_PIN, 24'h000033);

      // one frame: drive the pin count into saturation, then release twice
      setup_phase(1'b0, 5'd1, 2);
      for (int i = 0; i < 257; i++) send(OP_PIN, 24'h00C0DE);
      for (int i = 0; i < 2; i++) send(OP_UNPIN, 24'h00C0DE);

      // random phases over both policies and the frame-count extremes
      setup_phase(1'b0, 5'd16, 20);
      hold_request = 1'b1;
      random_items(30);
      setup_phase(1'b1, 5'd16, 22);
      random_items(30);
      setup_phase(1'b1, 5'd0, 3);
      random_items(20);
      setup_phase(1'b0, 5'd31, 24);
      random_items(30);
      setup_phase(1'b1, 5'd4, 7);
      random_items(30);
      setup_phase(1'b0, 5'd5, 8);
      random_items(30);
      quiet = 1'b1;
      setup_phase(1'b1, 5'd10, 14);
      random_items(40);

      settle();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bfm_pkg.sv
sv/buffer_frame_manager.sv
tb/sv/bfm_checker.sv
tb/sv/tb_buffer_frame_manager.sv
